[rtl/yuv2rgba_pkg.sv]
// Shared types, register codes and helper functions of the YUV 4:2:0 to RGBA converter.
package yuv2rgba_pkg;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 8;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LUMA_GAIN      = 3'd0,
    CFG_RED_FROM_CR    = 3'd1,
    CFG_BLUE_FROM_CB   = 3'd2,
    CFG_GREEN_FROM_CB  = 3'd3,
    CFG_GREEN_FROM_CR  = 3'd4,
    CFG_LUMA_BLACK     = 3'd5,
    CFG_ALPHA_ENABLE   = 3'd6
  } cfg_reg_e;

  localparam logic [7:0] LumaGainRst     = 8'd149;
  localparam logic [7:0] RedFromCrRst    = 8'd102;
  localparam logic [7:0] BlueFromCbRst   = 8'd129;
  localparam logic [7:0] GreenFromCbRst  = 8'd50;
  localparam logic [7:0] GreenFromCrRst  = 8'd104;
  localparam logic [7:0] LumaBlackRst    = 8'd16;
  localparam logic [7:0] AlphaOpaque     = 8'd255;
  localparam logic [8:0] ChromaNeutral   = 9'd128;

  typedef struct packed {
    logic signed [10:0] red;
    logic signed [10:0] green;
    logic signed [10:0] blue;
  } chroma_ofs_t;

  typedef struct packed {
    logic load_s1;
    logic load_out;
  } lane_ctrl_t;

  function automatic logic [7:0] clamp_byte(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

[rtl/yuv2rgba_chroma.sv]
// Shared chroma stage: forms the red, green and blue offsets of one block.
module yuv2rgba_chroma (
  input  logic                      clk_i,
  input  logic                      load_i,
  input  logic [7:0]                cb_i,
  input  logic [7:0]                cr_i,
  input  logic [7:0]                red_gain_i,
  input  logic [7:0]                blue_gain_i,
  input  logic [7:0]                green_cb_gain_i,
  input  logic [7:0]                green_cr_gain_i,
  output yuv2rgba_pkg::chroma_ofs_t ofs_o
);

  logic signed [8:0]  cb_c;
  logic signed [8:0]  cr_c;
  logic signed [16:0] red_prod_d, red_prod_q;
  logic signed [16:0] blue_prod_d, blue_prod_q;
  logic signed [16:0] gcb_prod;
  logic signed [16:0] gcr_prod;
  logic signed [17:0] green_sum_d, green_sum_q;

  assign cb_c = $signed({1'b0, cb_i} - yuv2rgba_pkg::ChromaNeutral);
  assign cr_c = $signed({1'b0, cr_i} - yuv2rgba_pkg::ChromaNeutral);

  assign red_prod_d  = cr_c * $signed({1'b0, red_gain_i});
  assign blue_prod_d = cb_c * $signed({1'b0, blue_gain_i});
  assign gcb_prod    = cb_c * $signed({1'b0, green_cb_gain_i});
  assign gcr_prod    = cr_c * $signed({1'b0, green_cr_gain_i});
  assign green_sum_d = $signed({gcb_prod[16], gcb_prod}) + $signed({gcr_prod[16], gcr_prod});

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      red_prod_q  <= red_prod_d;
      blue_prod_q <= blue_prod_d;
      green_sum_q <= green_sum_d;
    end
  end

  assign ofs_o.red   = red_prod_q[16:6];
  assign ofs_o.blue  = blue_prod_q[16:6];
  assign ofs_o.green = green_sum_q[17:7];

endmodule

[rtl/yuv2rgba_lane.sv]
// One pixel lane: scales a luma sample, applies the chroma offsets, clamps and packs RGBA.
module yuv2rgba_lane (
  input  logic                      clk_i,
  input  yuv2rgba_pkg::lane_ctrl_t  ctrl_i,
  input  logic [7:0]                luma_i,
  input  logic [7:0]                alpha_i,
  input  logic [7:0]                gain_i,
  input  logic [7:0]                black_i,
  input  logic                      alpha_en_i,
  input  yuv2rgba_pkg::chroma_ofs_t ofs_i,
  output logic [31:0]               pixel_o
);

  logic signed [8:0]  y_diff;
  logic signed [17:0] prod_d, prod_q;
  logic [7:0]         alpha_q;
  logic signed [10:0] luma_term;
  logic signed [11:0] red_sum;
  logic signed [11:0] green_sum;
  logic signed [11:0] blue_sum;
  logic [7:0]         alpha_out;
  logic [31:0]        pixel_d, pixel_q;

  assign y_diff = $signed({1'b0, luma_i}) - $signed({1'b0, black_i});
  assign prod_d = y_diff * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_s1) begin
      prod_q  <= prod_d;
      alpha_q <= alpha_i;
    end
  end

  assign luma_term = prod_q[17:7];
  assign red_sum   = $signed({luma_term[10], luma_term}) + $signed({ofs_i.red[10], ofs_i.red});
  assign green_sum = $signed({luma_term[10], luma_term})
                   - $signed({ofs_i.green[10], ofs_i.green});
  assign blue_sum  = $signed({luma_term[10], luma_term}) + $signed({ofs_i.blue[10], ofs_i.blue});
  assign alpha_out = alpha_en_i ? alpha_q : yuv2rgba_pkg::AlphaOpaque;

  assign pixel_d = {alpha_out,
                    yuv2rgba_pkg::clamp_byte(blue_sum),
                    yuv2rgba_pkg::clamp_byte(green_sum),
                    yuv2rgba_pkg::clamp_byte(red_sum)};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

[rtl/yuv420_block_to_rgba_unit.sv]
// Top level of the YUV 4:2:0 block to RGBA converter with its register file and flow control.
//
// Each input request carries one 2x2 block of a 4:2:0 frame: four luma samples, one shared
// Cb and Cr sample and four alpha bytes. Each output request carries the four packed RGBA
// pixels of that block, red in the low byte and alpha in the high byte.
// Both channels use valid and ready. Unless stalled, a block is taken every cycle: four lanes
// convert the four pixels side by side while one shared chroma unit forms the color offsets.
// The path has two register stages, the multiplier stage and the output register, and the
// sustained rate is one block per clock cycle while the receiver keeps ready high.
// When the receiver holds ready low, the finished block waits in the output register and
// one more block can still be taken into the multiplier stage; after that in_ready_o drops
// until the output drains.
// The configuration channel is always ready; registers are written by index and should
// only be changed while no block is in flight.
// Reset, asynchronous and active low, empties the pipeline and loads the default
// coefficients for limited range BT.601 with alpha forced opaque.
module yuv420_block_to_rgba_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [yuv2rgba_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [yuv2rgba_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [7:0]                            luma_top_left_i,
  input  logic [7:0]                            luma_top_right_i,
  input  logic [7:0]                            luma_bottom_left_i,
  input  logic [7:0]                            luma_bottom_right_i,
  input  logic [7:0]                            chroma_blue_i,
  input  logic [7:0]                            chroma_red_i,
  input  logic [7:0]                            alpha_top_left_i,
  input  logic [7:0]                            alpha_top_right_i,
  input  logic [7:0]                            alpha_bottom_left_i,
  input  logic [7:0]                            alpha_bottom_right_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [31:0]                           pixel_top_left_o,
  output logic [31:0]                           pixel_top_right_o,
  output logic [31:0]                           pixel_bottom_left_o,
  output logic [31:0]                           pixel_bottom_right_o
);

  logic [7:0] luma_gain_q, luma_gain_d;
  logic [7:0] red_gain_q, red_gain_d;
  logic [7:0] blue_gain_q, blue_gain_d;
  logic [7:0] gcb_gain_q, gcb_gain_d;
  logic [7:0] gcr_gain_q, gcr_gain_d;
  logic [7:0] black_q, black_d;
  logic       alpha_en_q, alpha_en_d;

  logic       s1_valid_q, s1_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       cfg_we;

  yuv2rgba_pkg::lane_ctrl_t  ctrl;
  yuv2rgba_pkg::chroma_ofs_t ofs;

  logic [yuv2rgba_pkg::NumLanes-1:0][7:0]  lane_luma;
  logic [yuv2rgba_pkg::NumLanes-1:0][7:0]  lane_alpha;
  logic [yuv2rgba_pkg::NumLanes-1:0][31:0] lane_pixel;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_comb begin
    luma_gain_d = luma_gain_q;
    red_gain_d  = red_gain_q;
    blue_gain_d = blue_gain_q;
    gcb_gain_d  = gcb_gain_q;
    gcr_gain_d  = gcr_gain_q;
    black_d     = black_q;
    alpha_en_d  = alpha_en_q;
    if (cfg_we) begin
      unique case (yuv2rgba_pkg::cfg_reg_e'(cfg_index_i))
        yuv2rgba_pkg::CFG_LUMA_GAIN:     luma_gain_d = cfg_data_i;
        yuv2rgba_pkg::CFG_RED_FROM_CR:   red_gain_d  = cfg_data_i;
        yuv2rgba_pkg::CFG_BLUE_FROM_CB:  blue_gain_d = cfg_data_i;
        yuv2rgba_pkg::CFG_GREEN_FROM_CB: gcb_gain_d  = cfg_data_i;
        yuv2rgba_pkg::CFG_GREEN_FROM_CR: gcr_gain_d  = cfg_data_i;
        yuv2rgba_pkg::CFG_LUMA_BLACK:    black_d     = cfg_data_i;
        yuv2rgba_pkg::CFG_ALPHA_ENABLE:  alpha_en_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ctrl.load_out = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o    = ~s1_valid_q | ctrl.load_out;
  assign ctrl.load_s1  = in_valid_i & in_ready_o;

  assign s1_valid_d  = ctrl.load_s1 | (s1_valid_q & ~ctrl.load_out);
  assign out_valid_d = ctrl.load_out | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_gain_q <= yuv2rgba_pkg::LumaGainRst;
      red_gain_q  <= yuv2rgba_pkg::RedFromCrRst;
      blue_gain_q <= yuv2rgba_pkg::BlueFromCbRst;
      gcb_gain_q  <= yuv2rgba_pkg::GreenFromCbRst;
      gcr_gain_q  <= yuv2rgba_pkg::GreenFromCrRst;
      black_q     <= yuv2rgba_pkg::LumaBlackRst;
      alpha_en_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      luma_gain_q <= luma_gain_d;
      red_gain_q  <= red_gain_d;
      blue_gain_q <= blue_gain_d;
      gcb_gain_q  <= gcb_gain_d;
      gcr_gain_q  <= gcr_gain_d;
      black_q     <= black_d;
      alpha_en_q  <= alpha_en_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  yuv2rgba_chroma u_chroma (
    .clk_i           (clk_i),
    .load_i          (ctrl.load_s1),
    .cb_i            (chroma_blue_i),
    .cr_i            (chroma_red_i),
    .red_gain_i      (red_gain_q),
    .blue_gain_i     (blue_gain_q),
    .green_cb_gain_i (gcb_gain_q),
    .green_cr_gain_i (gcr_gain_q),
    .ofs_o           (ofs)
  );

  assign lane_luma[0]  = luma_top_left_i;
  assign lane_luma[1]  = luma_top_right_i;
  assign lane_luma[2]  = luma_bottom_left_i;
  assign lane_luma[3]  = luma_bottom_right_i;
  assign lane_alpha[0] = alpha_top_left_i;
  assign lane_alpha[1] = alpha_top_right_i;
  assign lane_alpha[2] = alpha_bottom_left_i;
  assign lane_alpha[3] = alpha_bottom_right_i;

  for (genvar g = 0; g < yuv2rgba_pkg::NumLanes; g++) begin : g_lane
    yuv2rgba_lane u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .luma_i     (lane_luma[g]),
      .alpha_i    (lane_alpha[g]),
      .gain_i     (luma_gain_q),
      .black_i    (black_q),
      .alpha_en_i (alpha_en_q),
      .ofs_i      (ofs),
      .pixel_o    (lane_pixel[g])
    );
  end

  assign out_valid_o          = out_valid_q;
  assign pixel_top_left_o     = lane_pixel[0];
  assign pixel_top_right_o    = lane_pixel[1];
  assign pixel_bottom_left_o  = lane_pixel[2];
  assign pixel_bottom_right_o = lane_pixel[3];

  a_empty_stage_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input not ready although the multiplier stage is empty");

  a_accept_fills_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> s1_valid_q)
    else $error("accepted block did not enter the multiplier stage");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |->
      (!in_ready_o ##1 (s1_valid_q && out_valid_q)))
    else $error("multiplier stage lost or overwritten during an output stall");

  a_drain_empties_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && !s1_valid_q) |=> !out_valid_q)
    else $error("output stayed valid after its block was taken with nothing behind it");

endmodule

[dv/rgba_block_checker.sv]
// Checker that predicts the RGBA pixels of each accepted 2x2 block and compares them with the output.
module rgba_block_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [3:0][7:0]   luma_i,
  input  logic [7:0]        chroma_blue_i,
  input  logic [7:0]        chroma_red_i,
  input  logic [3:0][7:0]   alpha_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [3:0][31:0]  pixel_i,
  output int unsigned       mismatch_count_o,
  output int unsigned       blocks_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0][31:0] rgba_block_t;

  localparam string PixelName [4] = '{"pixel_top_left", "pixel_top_right",
                                      "pixel_bottom_left", "pixel_bottom_right"};

  logic [7:0] luma_gain_q;
  logic [7:0] red_gain_q;
  logic [7:0] blue_gain_q;
  logic [7:0] green_cb_gain_q;
  logic [7:0] green_cr_gain_q;
  logic [7:0] black_level_q;
  logic       alpha_en_q;

  rgba_block_t expected_pixels_q [$];
  int unsigned mismatches = 0;

  assign mismatch_count_o = mismatches;
  assign blocks_pending_o = expected_pixels_q.size();

  function automatic logic [7:0] saturate_byte(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  function automatic rgba_block_t convert_block(input logic [3:0][7:0] lumas,
                                                input logic [7:0] cb_raw,
                                                input logic [7:0] cr_raw,
                                                input logic [3:0][7:0] alphas);
    int          cb;
    int          cr;
    int          red_ofs;
    int          blue_ofs;
    int          green_ofs;
    int          lum;
    logic [7:0]  a;
    rgba_block_t px;
    cb = int'(cb_raw) - int'(yuv2rgba_pkg::ChromaNeutral);
    cr = int'(cr_raw) - int'(yuv2rgba_pkg::ChromaNeutral);
    red_ofs = (int'(red_gain_q) * cr) >>> 6;
    blue_ofs = (int'(blue_gain_q) * cb) >>> 6;
    green_ofs = (int'(green_cb_gain_q) * cb + int'(green_cr_gain_q) * cr) >>> 7;
    for (int k = 0; k < 4; k++) begin
      lum = (int'(luma_gain_q) * (int'(lumas[k]) - int'(black_level_q))) >>> 7;
      a = alpha_en_q ? alphas[k] : yuv2rgba_pkg::AlphaOpaque;
      px[k] = {a, saturate_byte(lum + blue_ofs), saturate_byte(lum - green_ofs),
               saturate_byte(lum + red_ofs)};
    end
    return px;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_gain_q     <= yuv2rgba_pkg::LumaGainRst;
      red_gain_q      <= yuv2rgba_pkg::RedFromCrRst;
      blue_gain_q     <= yuv2rgba_pkg::BlueFromCbRst;
      green_cb_gain_q <= yuv2rgba_pkg::GreenFromCbRst;
      green_cr_gain_q <= yuv2rgba_pkg::GreenFromCrRst;
      black_level_q   <= yuv2rgba_pkg::LumaBlackRst;
      alpha_en_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (yuv2rgba_pkg::cfg_reg_e'(cfg_index_i))
        yuv2rgba_pkg::CFG_LUMA_GAIN:     luma_gain_q     <= cfg_data_i;
        yuv2rgba_pkg::CFG_RED_FROM_CR:   red_gain_q      <= cfg_data_i;
        yuv2rgba_pkg::CFG_BLUE_FROM_CB:  blue_gain_q     <= cfg_data_i;
        yuv2rgba_pkg::CFG_GREEN_FROM_CB: green_cb_gain_q <= cfg_data_i;
        yuv2rgba_pkg::CFG_GREEN_FROM_CR: green_cr_gain_q <= cfg_data_i;
        yuv2rgba_pkg::CFG_LUMA_BLACK:    black_level_q   <= cfg_data_i;
        yuv2rgba_pkg::CFG_ALPHA_ENABLE:  alpha_en_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    rgba_block_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_pixels_q.push_back(convert_block(luma_i, chroma_blue_i, chroma_red_i,
                                                  alpha_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels_q.size() == 0) begin
          $error("output request with no block outstanding");
          mismatches++;
        end else begin
          want = expected_pixels_q.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (pixel_i[k] !== want[k]) begin
              $error("%s: expected %08h, actual %08h", PixelName[k], want[k], pixel_i[k]);
              mismatches++;
            end
          end
        end
      end
    end
  end

endmodule

[dv/yuv420_block_to_rgba_unit_tb.sv]
// Testbench top that drives blocks and register writes into the converter and gives the verdict.
module yuv420_block_to_rgba_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HoldOffCycles = 80;
  localparam int          StallLimit    = 2000;
  localparam logic [2:0]  CfgIdxUnused  = 3'd7;

  typedef struct packed {
    logic [3:0][7:0] luma;
    logic [7:0]      cb;
    logic [7:0]      cr;
    logic [3:0][7:0] alpha;
  } yuv_block_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  yuv_block_t  blk = '0;
  logic        out_ready = 1'b0;
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] pixel_top_left_o;
  logic [31:0] pixel_top_right_o;
  logic [31:0] pixel_bottom_left_o;
  logic [31:0] pixel_bottom_right_o;

  int          in_idle_pct = 34;
  int          out_idle_pct = 34;
  logic        hold_off_armed = 1'b0;
  bit          hold_off_done;
  int          stall_cycles;
  int unsigned blocks_sent;
  int unsigned reg_writes;
  int unsigned coeff_sets;
  int unsigned mismatch_count;
  int unsigned blocks_pending;

  yuv420_block_to_rgba_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .luma_top_left_i      (blk.luma[0]),
    .luma_top_right_i     (blk.luma[1]),
    .luma_bottom_left_i   (blk.luma[2]),
    .luma_bottom_right_i  (blk.luma[3]),
    .chroma_blue_i        (blk.cb),
    .chroma_red_i         (blk.cr),
    .alpha_top_left_i     (blk.alpha[0]),
    .alpha_top_right_i    (blk.alpha[1]),
    .alpha_bottom_left_i  (blk.alpha[2]),
    .alpha_bottom_right_i (blk.alpha[3]),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .pixel_top_left_o     (pixel_top_left_o),
    .pixel_top_right_o    (pixel_top_right_o),
    .pixel_bottom_left_o  (pixel_bottom_left_o),
    .pixel_bottom_right_o (pixel_bottom_right_o)
  );

  rgba_block_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready_o),
    .luma_i           (blk.luma),
    .chroma_blue_i    (blk.cb),
    .chroma_red_i     (blk.cr),
    .alpha_i          (blk.alpha),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready),
    .pixel_i          ({pixel_bottom_right_o, pixel_bottom_left_o,
                        pixel_top_right_o, pixel_top_left_o}),
    .mismatch_count_o (mismatch_count),
    .blocks_pending_o (blocks_pending)
  );

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic yuv_block_t random_block();
    yuv_block_t b;
    for (int k = 0; k < 4; k++) begin
      b.luma[k] = pick_byte();
      b.alpha[k] = pick_byte();
    end
    b.cb = pick_byte();
    b.cr = pick_byte();
    return b;
  endfunction

  function automatic yuv_block_t make_block(input logic [31:0] lumas, input logic [7:0] cb,
                                            input logic [7:0] cr, input logic [31:0] alphas);
    yuv_block_t b;
    b.luma = lumas;
    b.cb = cb;
    b.cr = cr;
    b.alpha = alphas;
    return b;
  endfunction

  task automatic offer_block(input yuv_block_t b);
    bit taken;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    blk <= b;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    blocks_sent++;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      offer_block(random_block());
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (blocks_pending == 0) begin
        break;
      end
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic load_coefficients(input logic [7:0] luma_gain, input logic [7:0] red_gain,
                                   input logic [7:0] blue_gain, input logic [7:0] g_cb_gain,
                                   input logic [7:0] g_cr_gain, input logic [7:0] black,
                                   input logic [7:0] alpha_word);
    wait_drained();
    write_reg(yuv2rgba_pkg::CFG_LUMA_GAIN, luma_gain);
    write_reg(yuv2rgba_pkg::CFG_RED_FROM_CR, red_gain);
    write_reg(yuv2rgba_pkg::CFG_BLUE_FROM_CB, blue_gain);
    write_reg(yuv2rgba_pkg::CFG_GREEN_FROM_CB, g_cb_gain);
    write_reg(yuv2rgba_pkg::CFG_GREEN_FROM_CR, g_cr_gain);
    write_reg(yuv2rgba_pkg::CFG_LUMA_BLACK, black);
    write_reg(yuv2rgba_pkg::CFG_ALPHA_ENABLE, alpha_word);
    coeff_sets++;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_armed && !hold_off_done) begin
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (cfg_valid && cfg_ready_o) || (in_valid && in_ready_o) ||
        (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == StallLimit) begin
        $display("timeout: no request accepted for %0d cycles", StallLimit);
        $display("yuv420_block_to_rgba_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    coeff_sets = 1;

    // Reset coefficients, first with alpha forced opaque and then with alpha enabled.
    offer_block(make_block(32'h00000000, 8'h00, 8'h00, 32'h00000000));
    offer_block(make_block(32'hFFFFFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    offer_block(make_block(32'hEB801000, 8'h80, 8'h80, 32'h12345678));
    offer_block(make_block(32'h0F1011FF, 8'h00, 8'hFF, 32'h00FF00FF));
    offer_block(make_block(32'h00FF00FF, 8'hFF, 8'h00, 32'h5A5A5A5A));
    offer_block(make_block(32'h40C01080, 8'h7F, 8'h81, 32'h00000000));
    offer_block(make_block(32'h40C01080, 8'h81, 8'h7F, 32'hFFFFFFFF));
    offer_block(make_block(32'h80808080, 8'h00, 8'h00, 32'hA5A5A5A5));
    offer_block(make_block(32'h80808080, 8'hFF, 8'hFF, 32'h5A5A5A5A));
    offer_block(make_block(32'h01FE7F80, 8'h01, 8'hFE, 32'hA5A5A5A5));
    wait_drained();
    write_reg(yuv2rgba_pkg::CFG_ALPHA_ENABLE, 8'h01);
    offer_block(make_block(32'hEBEB1010, 8'h80, 8'h80, 32'h00FFAA55));
    offer_block(make_block(32'h10EB10EB, 8'h00, 8'hFF, 32'hFF0055AA));
    offer_block(make_block(32'h00000000, 8'h00, 8'h00, 32'h00000000));
    offer_block(make_block(32'hFFFFFFFF, 8'hFF, 8'hFF, 32'hFFFFFFFF));
    send_random(300);

    // Largest gains with zero black level; a wide alpha word keeps only its low bit.
    load_coefficients(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF);
    write_reg(CfgIdxUnused, 8'($urandom_range(255)));
    send_random(250);

    // Zero gains with the highest black level and alpha disabled by a wide word.
    load_coefficients(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFE);
    send_random(250);

    // Random coefficients while the receiver holds off and the input backs up.
    load_coefficients(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)), 8'h01);
    hold_off_armed <= 1'b1;
    send_random(300);

    // Random coefficients at full rate with no idling on either side.
    load_coefficients(8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
    in_idle_pct <= 0;
    out_idle_pct <= 0;
    send_random(300);

    in_idle_pct <= 34;
    out_idle_pct <= 34;
    load_coefficients(yuv2rgba_pkg::LumaGainRst, yuv2rgba_pkg::RedFromCrRst,
                      yuv2rgba_pkg::BlueFromCbRst, yuv2rgba_pkg::GreenFromCbRst,
                      yuv2rgba_pkg::GreenFromCrRst, yuv2rgba_pkg::LumaBlackRst, 8'h01);
    send_random(200);

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("sent %0d blocks under %0d coefficient sets using %0d register writes",
             blocks_sent, coeff_sets, reg_writes);
    $display("covered alpha on and off, gain and black level extremes, and a %0d-cycle stall",
             HoldOffCycles);
    if (mismatch_count == 0) begin
      $display("yuv420_block_to_rgba_unit_tb: done, clean");
    end else begin
      $display("yuv420_block_to_rgba_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

[yuv420_block_to_rgba_unit.f]
rtl/yuv2rgba_pkg.sv
rtl/yuv2rgba_chroma.sv
rtl/yuv2rgba_lane.sv
rtl/yuv420_block_to_rgba_unit.sv
dv/rgba_block_checker.sv
dv/yuv420_block_to_rgba_unit_tb.sv
